FILE: rtl/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
// Used by bale_ctrl, bale_dp and bounded_array_list_engine_core. No dependencies.
package bale_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = 6;    // address width of the element store
    localparam int CW       = 7;    // width of counts and the capacity limit

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_SUB    = 3'd2;
    localparam logic [2:0] CMD_MUL    = 3'd3;
    localparam logic [2:0] CMD_DIV    = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;
    localparam logic [2:0] CMD_REMAT  = 3'd6;
    localparam logic [2:0] CMD_REMVAL = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INDEX   = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic          rd_en;     // read memory at rd_addr
        logic [AW-1:0] rd_addr;
        logic          wr_en;     // write result at wr_addr
        logic [AW-1:0] wr_addr;
        logic          div_start; // start a division on the read word
        logic          wr_opnd;   // write the operand (append) instead of the result
        logic          wr_raw;    // write the read word unchanged (shift)
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic        div_done;
        logic        match;       // last read word equals the operand
        logic [31:0] rd_word;
    } dp_stat_t;

endpackage

FILE: rtl/bale_dp.sv
// Datapath: element store, arithmetic unit and a radix-2 divider.
// Depends on bale_pkg.
module bale_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         op_cmd,
    input  logic [31:0]        op_value,
    input  bale_pkg::dp_cmd_t  cmd,
    output bale_pkg::dp_stat_t stat
);

    logic [31:0] mem [0:bale_pkg::CAPACITY-1];
    logic [31:0] rd_reg;
    logic [31:0] mul_reg;
    logic [31:0] wdata;
    logic [31:0] res;

    // Divider
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] dv_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [31:0] ma;
    logic [31:0] mb;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_reg <= mem[cmd.rd_addr];
        end
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wdata;
        end
        mul_reg <= rd_reg * op_value;
    end

    always_comb
    begin
        case (op_cmd)
            bale_pkg::CMD_ADD: res = rd_reg + op_value;
            bale_pkg::CMD_SUB: res = rd_reg - op_value;
            bale_pkg::CMD_MUL: res = mul_reg;
            bale_pkg::CMD_DIV: res = neg_reg ? (32'd0 - q_reg) : q_reg;
            default:           res = rd_reg;
        endcase
        if (cmd.wr_opnd)
        begin
            wdata = op_value;
        end
        else if (cmd.wr_raw)
        begin
            wdata = rd_reg;
        end
        else
        begin
            wdata = res;
        end
    end

    assign ma    = rd_reg[31] ? (32'd0 - rd_reg) : rd_reg;
    assign mb    = op_value[31] ? (32'd0 - op_value) : op_value;
    assign trial = {r_reg, q_reg[31]} - {1'b0, dv_reg};

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= ma;
                r_reg    <= '0;
                dv_reg   <= mb;
                neg_reg  <= rd_reg[31] ^ op_value[31];
            end
            else if (busy_reg)
            begin
                if (!trial[32])
                begin
                    r_reg <= trial[31:0];
                    q_reg <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[30:0], q_reg[31]};
                    q_reg <= {q_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.div_done = done_reg;
    assign stat.match    = (rd_reg == op_value);
    assign stat.rd_word  = rd_reg;

endmodule

FILE: rtl/bale_ctrl.sv
// Controller: sequences each command over the element store.
// Depends on bale_pkg.
module bale_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0]                   op_cmd,
    input  logic                         opnd_zero,
    input  logic [bale_pkg::AW-1:0]      op_index,
    input  logic [bale_pkg::CW-1:0]      limit,
    input  logic                         out_free,  // result register can take the result
    input  bale_pkg::dp_stat_t           stat,
    output bale_pkg::dp_cmd_t            cmd,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [31:0]                  rdata,
    output logic [bale_pkg::CW-1:0]      count
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // read issued, data arrives
    localparam logic [2:0] S_MUL  = 3'd2;  // product register fills
    localparam logic [2:0] S_DIV  = 3'd3;  // wait for divider
    localparam logic [2:0] S_WR   = 3'd4;  // write back, advance
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [bale_pkg::CW-1:0] cnt_reg, cnt_next;
    logic [bale_pkg::CW-1:0] i_reg, i_next;      // read pointer
    logic [bale_pkg::CW-1:0] w_reg, w_next;      // write pointer
    logic [1:0]              st_reg, st_next;
    logic [31:0]             rd_reg, rd_next;
    logic [bale_pkg::CW-1:0] eff;
    logic                    divst_reg;

    assign eff = (limit > bale_pkg::CW'(bale_pkg::CAPACITY))
                 ? bale_pkg::CW'(bale_pkg::CAPACITY) : limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            w_reg     <= '0;
            st_reg    <= bale_pkg::ST_OK;
            rd_reg    <= '0;
            divst_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            w_reg     <= w_next;
            st_reg    <= st_next;
            rd_reg    <= rd_next;
            divst_reg <= (state_next == S_RD) && (op_cmd == bale_pkg::CMD_DIV);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        w_next     = w_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        cmd        = '0;
        cmd.rd_addr = i_reg[bale_pkg::AW-1:0];
        cmd.wr_addr = w_reg[bale_pkg::AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next = bale_pkg::ST_OK;
                    rd_next = '0;
                    i_next  = '0;
                    w_next  = '0;
                    state_next = S_DONE;
                    case (op_cmd)
                        bale_pkg::CMD_APPEND:
                        begin
                            if (cnt_reg >= eff)
                            begin
                                st_next = bale_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_opnd = 1'b1;
                                cmd.wr_addr = cnt_reg[bale_pkg::AW-1:0];
                                cnt_next    = cnt_reg + 1'b1;
                            end
                        end
                        bale_pkg::CMD_READ:
                        begin
                            if ({1'b0, op_index} < cnt_reg)
                            begin
                                i_next     = {1'b0, op_index};
                                state_next = S_RD;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_addr = op_index;
                            end
                            else
                            begin
                                st_next = bale_pkg::ST_INDEX;
                            end
                        end
                        bale_pkg::CMD_REMAT:
                        begin
                            if ({1'b0, op_index} < cnt_reg)
                            begin
                                // shift from index+1 down to index
                                w_next   = {1'b0, op_index};
                                i_next   = {1'b0, op_index} + 1'b1;
                                cnt_next = cnt_reg - 1'b1;
                                if ({1'b0, op_index} + 1'b1 < cnt_reg)
                                begin
                                    state_next = S_RD;
                                    cmd.rd_en  = 1'b1;
                                    cmd.rd_addr = op_index + 1'b1;
                                end
                            end
                            else
                            begin
                                st_next = bale_pkg::ST_INDEX;
                            end
                        end
                        bale_pkg::CMD_DIV:
                        begin
                            if (opnd_zero)
                            begin
                                st_next = bale_pkg::ST_DIVZERO;
                            end
                            else if (cnt_reg != '0)
                            begin
                                state_next = S_RD;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_addr = '0;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = S_RD;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_addr = '0;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cmd.div_start = divst_reg;
                case (op_cmd)
                    bale_pkg::CMD_READ:
                    begin
                        rd_next    = stat.rd_word;
                        state_next = S_DONE;
                    end
                    bale_pkg::CMD_MUL: state_next = S_MUL;
                    bale_pkg::CMD_DIV: state_next = S_DIV;
                    default:           state_next = S_WR;
                endcase
            end
            S_MUL:
            begin
                state_next = S_WR;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                if (op_cmd == bale_pkg::CMD_REMVAL)
                begin
                    if (!stat.match)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_raw = 1'b1;
                        w_next     = w_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_raw = (op_cmd == bale_pkg::CMD_REMAT);
                    w_next     = w_reg + 1'b1;
                    if (op_cmd != bale_pkg::CMD_REMAT)
                    begin
                        cmd.wr_addr = i_reg[bale_pkg::AW-1:0];
                    end
                end
                i_next = i_reg + 1'b1;
                // REMAT already lowered the count, so its walk ends at cnt+1
                if ((op_cmd == bale_pkg::CMD_REMAT) ? (i_reg + 1'b1 > cnt_reg)
                                                    : (i_reg + 1'b1 >= cnt_reg))
                begin
                    state_next = S_DONE;
                    if (op_cmd == bale_pkg::CMD_REMVAL)
                    begin
                        cnt_next = stat.match ? w_reg : w_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next  = S_RD;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = i_next[bale_pkg::AW-1:0];
                end
            end
            S_DONE:
            begin
                // hold the result until the output register can take it
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == S_DONE);
    assign status = st_reg;
    assign rdata  = rd_reg;
    assign count  = cnt_reg;

endmodule

FILE: rtl/bounded_array_list_engine_core.sv
// Top level of the bounded array list engine: handshakes, limit register, result register.
// Depends on bale_pkg, bale_ctrl and bale_dp.

// One command is worked at a time. Append, a failed index check, divide by zero and
// any walk over an empty list go straight to the done state; a read first passes
// through the read state. Add, subtract and both removes read and write back each entry
// walked, multiply also fills the product register and divide waits on the
// one-bit-per-cycle divider. Remove at index walks only the entries above the
// index. A finished result waits in the output register while the next command is
// accepted; if that command finishes before the waiting result is taken, its result
// is held in the controller until the output register frees.
module bounded_array_list_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // cmd[2:0], operand_value[34:3], entry_index[40:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // read_data[31:0], status[33:32], entry_count[40:34]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data       // capacity_limit
);

    logic [6:0]         limit_reg;
    logic               busy_reg;
    logic [2:0]         cmd_reg;
    logic [31:0]        opv_reg;
    logic               ov_reg;
    logic [47:0]        out_reg;
    logic               accept;
    logic               done;
    logic [1:0]         status;
    logic [31:0]        rdata;
    logic [6:0]         count;
    bale_pkg::dp_cmd_t  dcmd;
    bale_pkg::dp_stat_t dstat;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 7'd64;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cmd_reg   <= '0;
            opv_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
                cmd_reg  <= s_axis_tdata[2:0];
                opv_reg  <= s_axis_tdata[34:3];
            end
            else if (done && (!ov_reg || m_axis_tready))
            begin
                busy_reg <= 1'b0;
            end
            // hold the result until taken; the controller holds done otherwise
            if (done && (!ov_reg || m_axis_tready))
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && (!ov_reg || m_axis_tready))
        begin
            out_reg <= {7'd0, count, status, rdata};
        end
    end

    // The controller sees the command on the accept edge via the raw bus.
    bale_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .op_cmd    (accept ? s_axis_tdata[2:0] : cmd_reg),
        .opnd_zero (s_axis_tdata[34:3] == 32'd0),
        .op_index  (s_axis_tdata[40:35]),
        .limit     (limit_reg),
        .out_free  (!ov_reg || m_axis_tready),
        .stat      (dstat),
        .cmd       (dcmd),
        .done      (done),
        .status    (status),
        .rdata     (rdata),
        .count     (count)
    );

    bale_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_cmd   (cmd_reg),
        .op_value (accept ? s_axis_tdata[34:3] : opv_reg),
        .cmd      (dcmd),
        .stat     (dstat)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    // done waits while busy; it must not repeat once the result is latched
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready) else $error("accepted while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= 7'd64) else $error("count past capacity");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("done with no command");

endmodule
